@@ hdl/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, sizes and pointer helpers for the stereo playback FIFO.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Frames the ring can hold; pointers run modulo twice this value
  localparam int unsigned FIFO_DEPTH = 16384;
  localparam int unsigned ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned PTR_W      = $clog2(2 * FIFO_DEPTH);
  // Fill level needs one more bit than a pointer for the wrapped difference
  localparam int unsigned CNT_W      = PTR_W + 1;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned FRAME_W    = 2 * SAMPLE_W;
  localparam int unsigned HELD_W     = 15;
  localparam int unsigned TOTAL_W    = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [SAMPLE_W-1:0] left_in;
    logic [SAMPLE_W-1:0] right_in;
    logic                batch_end;
  } in_beat_t;

  typedef struct packed {
    logic                accepted;
    logic [SAMPLE_W-1:0] left_out;
    logic [SAMPLE_W-1:0] right_out;
    logic                zero_filled;
    logic [HELD_W-1:0]   held_count;
    logic [TOTAL_W-1:0]  underrun_count;
    logic [TOTAL_W-1:0]  taken_count;
  } out_beat_t;

  // Result waiting for its frame data from the store
  typedef struct packed {
    out_beat_t beat;
    logic      use_ram;
  } pend_t;

  // Advance a pointer, wrapping at twice the depth
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(2 * FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Map a pointer onto a store address
  function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= PTR_W'(FIFO_DEPTH)) ? p - PTR_W'(FIFO_DEPTH) : p;
    return ADDR_W'(s);
  endfunction

endpackage

@@ hdl/spf_ram.sv @@
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/stereo_playback_fifo_core.sv @@
// ----------------------------------------------------------------------------
// stereo_playback_fifo_core
// Ring FIFO of stereo frames between a producer and a playback sink, with
// period underrun tracking and a delivered-frame count.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 beat
//   in        sink       in_valid_i / in_stall_o   spf_pkg::in_beat_t
//   out       source     out_valid_o / out_stall_i spf_pkg::out_beat_t
//
// One command a cycle unless stalled; results pass pending and output registers.
// Pointers and counters update when a command is taken; a pull reads the
// frame store's registered port, so its result waits one stage for the data.
// Reset clears pointers, counters and the starved flag; the store is not
// cleared, since only written entries are ever read.
// Input stalls only while the pending stage is full and the output is stalled.
// ----------------------------------------------------------------------------
module stereo_playback_fifo_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spf_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spf_pkg::out_beat_t out_beat_o
);
  import spf_pkg::*;

  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic               starved_q, starved_d;
  logic [TOTAL_W-1:0] underrun_q, underrun_d;
  logic [TOTAL_W-1:0] taken_q, taken_d;

  logic               pend_valid_q;
  pend_t              pend_q, pend_d;
  logic               out_valid_q;
  out_beat_t          out_q, out_d;

  logic               in_take;
  logic               pend_move;
  logic [CNT_W-1:0]   held_now;
  logic [CNT_W-1:0]   held_after;
  logic               fill_pull;
  logic               ram_we;
  logic               ram_re;
  logic [FRAME_W-1:0] ram_rdata;

  // Handshake: the pending stage drains when the output register frees up
  assign pend_move  = pend_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pend_valid_q && !pend_move;
  assign in_take    = in_valid_i && !in_stall_o;

  // Fill level from the current pointers
  assign held_now = (wr_ptr_q >= rd_ptr_q)
                  ? CNT_W'(wr_ptr_q) - CNT_W'(rd_ptr_q)
                  : CNT_W'(wr_ptr_q) + CNT_W'(2 * FIFO_DEPTH) - CNT_W'(rd_ptr_q);
  assign fill_pull = starved_q || (held_now == '0);

  // Execute the command against the control state
  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    starved_d  = starved_q;
    underrun_d = underrun_q;
    taken_d    = taken_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    pend_d     = '0;
    held_after = held_now;
    if (in_take) begin
      case (in_beat_i.cmd)
        CMD_PUSH: begin
          if (held_now < CNT_W'(FIFO_DEPTH)) begin
            ram_we                = 1'b1;
            wr_ptr_d              = ptr_next(wr_ptr_q);
            held_after            = held_now + 1'b1;
            pend_d.beat.accepted  = 1'b1;
          end
        end
        CMD_PULL: begin
          pend_d.beat.zero_filled = fill_pull;
          if (!fill_pull) begin
            ram_re         = 1'b1;
            pend_d.use_ram = 1'b1;
            rd_ptr_d       = ptr_next(rd_ptr_q);
            taken_d        = taken_q + 1'b1;
            held_after     = held_now - 1'b1;
          end
          if (in_beat_i.batch_end) begin
            if (fill_pull) begin
              underrun_d = underrun_q + 1'b1;
            end
            starved_d = 1'b0;
          end else begin
            starved_d = fill_pull;
          end
        end
        CMD_CLEAR: begin
          underrun_d = '0;
          taken_d    = '0;
        end
        default: begin
        end
      endcase
    end
    pend_d.beat.held_count     = HELD_W'(held_after);
    pend_d.beat.underrun_count = underrun_d;
    pend_d.beat.taken_count    = taken_d;
  end

  // Frame store: left sample in the low half, right in the high half
  spf_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_slot(wr_ptr_q)),
    .wdata_i ({in_beat_i.right_in, in_beat_i.left_in}),
    .re_i    (ram_re),
    .raddr_i (ptr_slot(rd_ptr_q)),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      starved_q  <= 1'b0;
      underrun_q <= '0;
      taken_q    <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      starved_q  <= starved_d;
      underrun_q <= underrun_d;
      taken_q    <= taken_d;
    end
  end

  // Pending stage and output register valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_take) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Merge frame data from the store into the pending beat
  always_comb begin
    out_d = pend_q.beat;
    if (pend_q.use_ram) begin
      out_d.left_out  = ram_rdata[SAMPLE_W-1:0];
      out_d.right_out = ram_rdata[FRAME_W-1:SAMPLE_W];
    end
  end

  // Payload: capture the pending beat, then advance it to the output
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pend_q <= pend_d;
    end
    if (pend_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTHESIS
  // Fill level never exceeds the ring
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_now <= CNT_W'(FIFO_DEPTH))
    else $error("fill level beyond depth");

  // A store read is followed by a pending beat that takes its data
  a_read_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (pend_valid_q && pend_q.use_ram))
    else $error("store read without pending beat");

  // Stalling the input implies the pending stage is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (pend_valid_q && out_valid_q))
    else $error("input stalled with free pipeline");

  // Zero-filled beats carry silence
  a_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.zero_filled) |->
      (out_beat_o.left_out == '0 && out_beat_o.right_out == '0))
    else $error("zero-filled beat with sample data");
`endif

endmodule

@@ tb/tb_stereo_playback_fifo_core.sv @@
// ----------------------------------------------------------------------------
// tb_stereo_playback_fifo_core
// Self-checking bench for the stereo playback FIFO core. An untimed model
// of the ring (stored frames, starved period flag, underrun and delivered
// counters) predicts every result beat, which is compared field by field with
// the core's output. Stimulus covers directed corner cases and random traffic
// under varying source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_stereo_playback_fifo_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  // Playback FIFO model plus the queue of result beats still owed by the core
  class playback_ledger;
    logic [FRAME_W-1:0] queued_frames[$];
    logic               starved;
    logic [TOTAL_W-1:0] underruns;
    logic [TOTAL_W-1:0] delivered;
    out_beat_t          owed_results[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        refused_pushes;
    int unsigned        silent_pulls;
    int unsigned        starved_periods;

    function new();
      starved   = 1'b0;
      underruns = '0;
      delivered = '0;
    endfunction

    // Apply one accepted command and queue the result it must produce
    function void take_command(in_beat_t b);
      out_beat_t          r;
      logic [FRAME_W-1:0] frame;
      r = '0;
      case (b.cmd)
        CMD_PUSH: begin
          if (queued_frames.size() < FIFO_DEPTH) begin
            queued_frames.push_back({b.right_in, b.left_in});
            r.accepted = 1'b1;
          end else begin
            refused_pushes++;
          end
        end
        CMD_PULL: begin
          // An empty FIFO starves the rest of the period
          if (queued_frames.size() == 0) starved = 1'b1;
          if (starved) begin
            r.zero_filled = 1'b1;
            silent_pulls++;
          end else begin
            frame       = queued_frames.pop_front();
            r.left_out  = frame[SAMPLE_W-1:0];
            r.right_out = frame[FRAME_W-1:SAMPLE_W];
            delivered   = delivered + 1'b1;
          end
          if (b.batch_end) begin
            if (starved) begin
              underruns = underruns + 1'b1;
              starved_periods++;
            end
            starved = 1'b0;
          end
        end
        CMD_CLEAR: begin
          underruns = '0;
          delivered = '0;
        end
        default: ;
      endcase
      r.held_count     = HELD_W'(queued_frames.size());
      r.underrun_count = underruns;
      r.taken_count    = delivered;
      owed_results.push_back(r);
    endfunction

    function void note_failure(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("beat %0d %s: expected %h, got %h", checked, what, want, got);
    endfunction

    function void diff_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) note_failure(what, want, got);
    endfunction

    // Compare one output beat with the oldest owed result
    function void check_result(out_beat_t got);
      out_beat_t want;
      if (owed_results.size() == 0) begin
        note_failure("unexpected beat, taken_count", '0, got.taken_count);
        return;
      end
      want = owed_results.pop_front();
      checked++;
      diff_field("accepted", 32'(want.accepted), 32'(got.accepted));
      diff_field("left_out", want.left_out, got.left_out);
      diff_field("right_out", want.right_out, got.right_out);
      diff_field("zero_filled", 32'(want.zero_filled), 32'(got.zero_filled));
      diff_field("held_count", 32'(want.held_count), 32'(got.held_count));
      diff_field("underrun_count", want.underrun_count, got.underrun_count);
      diff_field("taken_count", want.taken_count, got.taken_count);
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  playback_ledger ledger;
  int unsigned    source_idle_pct = 0;
  int unsigned    sink_stall_pct  = 0;
  int unsigned    beats_sent      = 0;

  stereo_playback_fifo_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic in_beat_t make_beat(cmd_e c, logic [31:0] l, logic [31:0] r,
                                         logic last);
    in_beat_t b;
    b.cmd       = c;
    b.left_in   = l;
    b.right_in  = r;
    b.batch_end = last;
    return b;
  endfunction

  // Random sample word, now and then pinned to all zeros or all ones
  function automatic logic [31:0] random_sample();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random command; push_weight biases the fill level up or down
  function automatic in_beat_t random_beat(int unsigned push_weight);
    in_beat_t    b;
    int unsigned roll;
    roll        = $urandom_range(99);
    b.left_in   = random_sample();
    b.right_in  = random_sample();
    b.batch_end = 1'($urandom_range(1));
    if (roll < push_weight) begin
      b.cmd = CMD_PUSH;
    end else if (roll < 92) begin
      b.cmd       = CMD_PULL;
      b.batch_end = ($urandom_range(5) == 0);
    end else if (roll < 96) begin
      b.cmd = CMD_CLEAR;
    end else begin
      b.cmd = CMD_NOP;
    end
    return b;
  endfunction

  // Offer one beat after a random idle gap and hold it until taken
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < source_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.take_command(b);
    beats_sent++;
  endtask

  // Hold the source off until every owed result has arrived
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (ledger.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Sink: check accepted beats and stall at random
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) ledger.check_result(out_beat_o);
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("stereo_playback_fifo_core: mismatch");
    $finish;
  end

  initial begin
    int unsigned push_weight;
    push_weight = 45;
    ledger = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: starvation, pushes while starved, clears, extremes, no-op
    send_beat(make_beat(CMD_PULL, '1, '1, 1'b0));
    send_beat(make_beat(CMD_PUSH, '0, '0, 1'b0));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b0));
    send_beat(make_beat(CMD_CLEAR, '0, '0, 1'b0));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b1));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b1));
    send_beat(make_beat(CMD_PUSH, '1, '1, 1'b1));
    send_beat(make_beat(CMD_PUSH, '1, '0, 1'b0));
    send_beat(make_beat(CMD_PUSH, '0, '1, 1'b1));
    send_beat(make_beat(CMD_NOP, '1, '1, 1'b1));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b0));
    send_beat(make_beat(CMD_PULL, '1, '1, 1'b0));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b0));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b0));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b1));
    send_beat(make_beat(CMD_CLEAR, '1, '1, 1'b1));
    send_beat(make_beat(CMD_PUSH, 32'h8000_0000, 32'h7F80_0000, 1'b0));
    send_beat(make_beat(CMD_PUSH, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b1));
    send_beat(make_beat(CMD_PULL, '0, '0, 1'b0));
    send_beat(make_beat(CMD_NOP, '0, '0, 1'b0));
    wait_for_results();

    // Random traffic: busy sink, then idle source, then no idling at all
    for (int phase = 0; phase < 3; phase++) begin
      source_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 83 : 0;
      sink_stall_pct  = (phase == 0) ? 83 : (phase == 1) ? 35 : 0;
      for (int n = 0; n < 200; n++) begin
        if (n % 25 == 0) push_weight = 25 + 20 * $urandom_range(2);
        send_beat(random_beat(push_weight));
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk_i);
    $display("sent %0d commands, checked %0d results", beats_sent, ledger.checked);
    $display("full-FIFO drops %0d, silent pulls %0d, underrun periods %0d",
             ledger.refused_pushes, ledger.silent_pulls, ledger.starved_periods);
    if (ledger.mismatches == 0) begin
      $display("stereo_playback_fifo_core: match");
    end else begin
      $display("stereo_playback_fifo_core: mismatch");
    end
    $finish;
  end

endmodule
